/* sv/ppr_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppr_pkg: shared types and constants for planar point rotation
// Fixed-point formats, CORDIC step count, arctangent table and gain constant.
// The tables are built at elaboration by constant functions.
// ---------------------------------------------------------------------------
package ppr_pkg;

    // Number of CORDIC steps requested, and the hard upper limit
    localparam int ROTATION_STEPS = 16;
    localparam int MAX_STEPS      = 30;
    localparam int NSTEPS         = (ROTATION_STEPS < MAX_STEPS) ? ROTATION_STEPS : MAX_STEPS;
    localparam int STEP_W         = $clog2(MAX_STEPS);

    // Field and datapath widths
    localparam int FIELD_W = 32;                 // every stream field
    localparam int GUARD_W = 16;                 // extra fraction bits on x and y
    localparam int XY_W    = 51;                 // Q16.32 plus growth headroom
    localparam int Z_W     = 32;                 // Q4.28 angle
    localparam int FOLD_W  = Z_W + 1;            // heading fold needs one more bit
    localparam int TDATA_W = 3 * FIELD_W;

    // Output scaling: magnitude split into high and low parts
    localparam int GAIN_W    = 31;               // gain K in Q1.30
    localparam int GAIN_FRAC = 30;
    localparam int LOW_W     = 25;
    localparam int MH_W      = XY_W - LOW_W;
    localparam int A_W       = MH_W + GAIN_W;
    localparam int B_W       = LOW_W + GAIN_W;
    localparam int SUM_W     = A_W + LOW_W + 1;
    localparam int OUT_SHIFT = GUARD_W + GAIN_FRAC;
    localparam int MAG_W     = SUM_W - OUT_SHIFT;

    // Angle constants in Q4.28
    localparam logic signed [FOLD_W-1:0] PI_FOLD      = 33'sd843314857;
    localparam logic signed [FOLD_W-1:0] TWO_PI_FOLD  = 33'sd1686629713;
    localparam logic signed [Z_W-1:0]    HALF_PI_Q28  = 32'sd421657428;
    localparam logic [63:0]              QUARTER_PI_Q28 = 64'd210828714;

    // One pipeline slot: working coordinates, residual angle, heading copy
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [FIELD_W-1:0]     heading;
    } ppr_cell_t;

    typedef logic [MAX_STEPS-1:0][Z_W-1:0] ppr_atan_tab_t;

    // Restoring bit-by-bit quotient, used only while building constants
    function automatic logic [63:0] quot64(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], num[b]};
            if (r >= den)
            begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Integer square root by the digit-pair method
    function automatic logic [63:0] isqrt64(logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_w;
        v     = v_in;
        res   = '0;
        bit_w = 64'd1 << 62;
        while (bit_w > v)
            bit_w = bit_w >> 2;
        while (bit_w != 64'd0)
        begin
            if (v >= res + bit_w)
            begin
                v   = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end
            else
            begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    // arctan(2^-i) in Q4.28 from its power series in Q0.62, round to nearest
    function automatic ppr_atan_tab_t build_atan_tab();
        ppr_atan_tab_t tab;
        logic [63:0]   sum;
        logic [63:0]   term;
        int            k;
        int            sh;
        tab    = '0;
        tab[0] = Z_W'(QUARTER_PI_Q28);
        for (int i = 1; i < MAX_STEPS; i++)
        begin
            sum = '0;
            k   = 0;
            while (i * (2 * k + 1) <= 62)
            begin
                sh   = 62 - i * (2 * k + 1);
                term = quot64(64'd1 << sh, 64'(2 * k + 1));
                if (k % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
                k = k + 1;
            end
            tab[i] = Z_W'((sum + (64'd1 << 33)) >> 34);
        end
        return tab;
    endfunction

    // Gain compensation K = 1 / prod sqrt(1 + 2^-2i) in Q1.30
    function automatic logic [63:0] build_gain();
        logic [63:0] p;
        logic [63:0] s;
        p = 64'd1 << 60;
        for (int i = 0; i < NSTEPS; i++)
            p = p + (p >> (2 * i));
        s = isqrt64(p);
        if (s == 64'd0)
            s = 64'd1;
        return quot64((64'd1 << 60) + (s >> 1), s);
    endfunction

    localparam ppr_atan_tab_t     ATAN_TAB = build_atan_tab();
    localparam logic [GAIN_W-1:0] GAIN_K   = GAIN_W'(build_gain());

endpackage

/* sv/ppr_prep.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppr_prep: heading fold and quadrant pre-rotation
// Folds the heading into (-pi, pi], negates it, and turns the point by
// +-pi/2 so the residual angle lies within [-pi/2 - 1 LSB, pi/2] for the CORDIC row.
// ---------------------------------------------------------------------------
module ppr_prep
    import ppr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FIELD_W-1:0] point_x,
    input  logic [FIELD_W-1:0] point_y,
    input  logic [FIELD_W-1:0] heading,
    output logic               out_valid,
    input  logic               out_ready,
    output ppr_cell_t          out_data
);

    logic                      valid_reg;
    ppr_cell_t                 data_reg;
    ppr_cell_t                 data_next;
    logic                      advance;
    logic signed [FOLD_W-1:0]  h_wide;
    logic signed [FOLD_W-1:0]  h_fold;
    logic signed [Z_W-1:0]     z_neg;
    logic signed [XY_W-1:0]    x_ext;
    logic signed [XY_W-1:0]    y_ext;

    // Take a new transfer whenever the slot is empty or drains this cycle
    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    // Fold heading, then pre-rotate by a quarter turn if needed
    always_comb
    begin
        h_wide = $signed({heading[FIELD_W-1], heading});
        if (h_wide > PI_FOLD)
            h_fold = h_wide - TWO_PI_FOLD;
        else if (h_wide <= -PI_FOLD)
            h_fold = h_wide + TWO_PI_FOLD;
        else
            h_fold = h_wide;
        z_neg = -$signed(h_fold[Z_W-1:0]);

        x_ext = $signed({{(XY_W - FIELD_W - GUARD_W){point_x[FIELD_W-1]}}, point_x,
                         {GUARD_W{1'b0}}});
        y_ext = $signed({{(XY_W - FIELD_W - GUARD_W){point_y[FIELD_W-1]}}, point_y,
                         {GUARD_W{1'b0}}});

        data_next.heading = heading;
        if (z_neg > HALF_PI_Q28)
        begin
            data_next.x = -y_ext;
            data_next.y = x_ext;
            data_next.z = z_neg - HALF_PI_Q28;
        end
        else if (z_neg < -HALF_PI_Q28)
        begin
            data_next.x = y_ext;
            data_next.y = -x_ext;
            data_next.z = z_neg + HALF_PI_Q28;
        end
        else
        begin
            data_next.x = x_ext;
            data_next.y = y_ext;
            data_next.z = z_neg;
        end
    end

    // Hold valid under reset; payload needs none
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* sv/ppr_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppr_cell: one CORDIC rotation step
// Turns (x, y) toward the residual angle by arctan(2^-step) and hands the
// result to the next cell. The step index is tied to a constant per cell.
// ---------------------------------------------------------------------------
module ppr_cell
    import ppr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [STEP_W-1:0] step,
    input  logic              in_valid,
    output logic              in_ready,
    input  ppr_cell_t         in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ppr_cell_t         out_data
);

    logic                   valid_reg;
    ppr_cell_t              data_reg;
    ppr_cell_t              data_next;
    logic                   advance;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  angle;

    // Move on when empty or when the neighbor takes the current item
    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    // Rotate by the sign of the residual angle
    always_comb
    begin
        dx    = in_data.x >>> step;
        dy    = in_data.y >>> step;
        angle = $signed(ATAN_TAB[step]);
        data_next.heading = in_data.heading;
        if (!in_data.z[Z_W-1])
        begin
            data_next.x = in_data.x - dy;
            data_next.y = in_data.y + dx;
            data_next.z = in_data.z - angle;
        end
        else
        begin
            data_next.x = in_data.x + dy;
            data_next.y = in_data.y - dx;
            data_next.z = in_data.z + angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* sv/ppr_scale.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppr_scale: gain compensation, rounding and saturation
// Stage one splits each magnitude and forms two partial products with K;
// stage two sums them, rounds half away from zero and clamps to 32 bits.
// ---------------------------------------------------------------------------
module ppr_scale
    import ppr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ppr_cell_t          in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [FIELD_W-1:0] local_x,
    output logic [FIELD_W-1:0] local_y,
    output logic [FIELD_W-1:0] local_heading
);

    logic               s1_valid_reg;
    logic               s1_neg_x_reg;
    logic               s1_neg_y_reg;
    logic [A_W-1:0]     s1_hi_x_reg;
    logic [B_W-1:0]     s1_lo_x_reg;
    logic [A_W-1:0]     s1_hi_y_reg;
    logic [B_W-1:0]     s1_lo_y_reg;
    logic [FIELD_W-1:0] s1_heading_reg;
    logic               out_valid_reg;
    logic [FIELD_W-1:0] local_x_reg;
    logic [FIELD_W-1:0] local_y_reg;
    logic [FIELD_W-1:0] local_heading_reg;
    logic               s1_advance;
    logic               s2_advance;
    logic [XY_W-1:0]    mag_x;
    logic [XY_W-1:0]    mag_y;

    // Sum partial products, round and clamp to the signed output range
    function automatic logic [FIELD_W-1:0] round_sat(logic neg, logic [A_W-1:0] hi,
                                                     logic [B_W-1:0] lo);
        logic [SUM_W-1:0] sum;
        logic [MAG_W-1:0] mag;
        logic [FIELD_W-1:0] r;
        sum = {1'b0, hi, {LOW_W{1'b0}}} + SUM_W'(lo) + (SUM_W'(1) << (OUT_SHIFT - 1));
        mag = sum[SUM_W-1:OUT_SHIFT];
        if (neg)
        begin
            if (mag > (MAG_W'(1) << (FIELD_W - 1)))
                r = {1'b1, {(FIELD_W - 1){1'b0}}};
            else
                r = FIELD_W'(0) - mag[FIELD_W-1:0];
        end
        else
        begin
            if (mag > MAG_W'({1'b0, {(FIELD_W - 1){1'b1}}}))
                r = {1'b0, {(FIELD_W - 1){1'b1}}};
            else
                r = mag[FIELD_W-1:0];
        end
        return r;
    endfunction

    assign s2_advance = !out_valid_reg || out_ready;
    assign s1_advance = !s1_valid_reg || s2_advance;
    assign in_ready   = s1_advance;

    // Take magnitudes of the CORDIC outputs
    always_comb
    begin
        mag_x = in_data.x[XY_W-1] ? XY_W'(-in_data.x) : XY_W'(in_data.x);
        mag_y = in_data.y[XY_W-1] ? XY_W'(-in_data.y) : XY_W'(in_data.y);
    end

    // Valid flags for both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_advance)
                s1_valid_reg <= in_valid;
            if (s2_advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Stage one: partial products with K
    always_ff @(posedge clk)
    begin
        if (s1_advance && in_valid)
        begin
            s1_neg_x_reg   <= in_data.x[XY_W-1];
            s1_neg_y_reg   <= in_data.y[XY_W-1];
            s1_hi_x_reg    <= A_W'(mag_x[XY_W-1:LOW_W]) * A_W'(GAIN_K);
            s1_lo_x_reg    <= B_W'(mag_x[LOW_W-1:0]) * B_W'(GAIN_K);
            s1_hi_y_reg    <= A_W'(mag_y[XY_W-1:LOW_W]) * A_W'(GAIN_K);
            s1_lo_y_reg    <= B_W'(mag_y[LOW_W-1:0]) * B_W'(GAIN_K);
            s1_heading_reg <= in_data.heading;
        end
    end

    // Stage two: output register
    always_ff @(posedge clk)
    begin
        if (s2_advance && s1_valid_reg)
        begin
            local_x_reg       <= round_sat(s1_neg_x_reg, s1_hi_x_reg, s1_lo_x_reg);
            local_y_reg       <= round_sat(s1_neg_y_reg, s1_hi_y_reg, s1_lo_y_reg);
            local_heading_reg <= s1_heading_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign local_x       = local_x_reg;
    assign local_y       = local_y_reg;
    assign local_heading = local_heading_reg;

endmodule

/* sv/planar_point_rotation_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// planar_point_rotation_top: rotate global points into the robot frame
// Each transfer on the input stream carries a Q16.16 point and a Q4.28
// heading. The block returns the point rotated by the negated heading,
// saturated to 32 bits, together with the unchanged heading.
//
// Channels: s_axis takes {heading, point_y, point_x}; m_axis returns
// {local_heading, local_y, local_x}, one output transfer per input transfer.
// Pipeline: one fold and pre-rotation stage, one cell per CORDIC step, then
// two scaling stages.
// Throughput: one item per cycle; every stage is a register slot, so the
// row accepts a transfer each cycle while any slot is free.
// Stall: when m_axis_tready is low the output register holds its item and
// the row keeps filling its empty slots; s_axis_tready drops only when
// every slot holds an item.
// Reset: rst_n clears all valid flags at once; the block is ready as soon as
// reset is released.
// ---------------------------------------------------------------------------
module planar_point_rotation_top
    import ppr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // point_x, point_y, heading
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata    // local_x, local_y, local_heading
);

    ppr_cell_t          stage_data  [NSTEPS+1];
    logic [NSTEPS:0]    stage_valid;
    logic [NSTEPS:0]    stage_ready;
    logic [FIELD_W-1:0] local_x;
    logic [FIELD_W-1:0] local_y;
    logic [FIELD_W-1:0] local_heading;

    // Fold the heading and pre-rotate
    ppr_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .point_x   (s_axis_tdata[FIELD_W-1:0]),
        .point_y   (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
        .heading   (s_axis_tdata[3*FIELD_W-1:2*FIELD_W]),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_data  (stage_data[0])
    );

    // Row of CORDIC cells, one per step
    for (genvar k = 0; k < NSTEPS; k++)
    begin : g_cell
        ppr_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (STEP_W'(k)),
            .in_valid  (stage_valid[k]),
            .in_ready  (stage_ready[k]),
            .in_data   (stage_data[k]),
            .out_valid (stage_valid[k+1]),
            .out_ready (stage_ready[k+1]),
            .out_data  (stage_data[k+1])
        );
    end

    // Gain compensation and output register
    ppr_scale u_scale
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (stage_valid[NSTEPS]),
        .in_ready      (stage_ready[NSTEPS]),
        .in_data       (stage_data[NSTEPS]),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .local_x       (local_x),
        .local_y       (local_y),
        .local_heading (local_heading)
    );

    assign m_axis_tdata = {local_heading, local_y, local_x};

`ifndef ASSERT_OFF
    // Input back-pressure only when every slot of the row is occupied
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> ((&stage_valid) && m_axis_tvalid))
        else $error("input stalled while the pipeline has a free slot");

    // An accepted transfer lands in the first slot
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> stage_valid[0])
        else $error("accepted transfer missing from the first stage");

    // Pre-rotation leaves the residual angle within a quarter turn; a heading
    // of exactly pi leaves one LSB beyond -pi/2
    a_prep_range: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid[0] |-> ((stage_data[0].z <= HALF_PI_Q28) &&
                            (stage_data[0].z >= -HALF_PI_Q28 - 1)))
        else $error("residual angle outside quarter turn after pre-rotation");
`endif

endmodule
